### design/key_long_press_auto_repeat_macros.svh
// Assertion macros shared by the key long-press and auto-repeat design.
`ifndef KEY_LONG_PRESS_AUTO_REPEAT_MACROS_SVH
`define KEY_LONG_PRESS_AUTO_REPEAT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of i_clk outside reset.
`define KLPAR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of i_clk outside reset.
`define KLPAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/klpar_pkg.sv
// Package with the key table, result types and lookup functions.
`default_nettype none

package klpar_pkg;

    localparam int KEY_ENTRIES = 17;
    localparam int TABLE_ROWS  = 17;
    localparam int SEARCH_ROWS = (KEY_ENTRIES < TABLE_ROWS) ? KEY_ENTRIES : TABLE_ROWS;
    localparam int ENTRY_W     = 5;
    localparam int KEY_W       = 25;
    localparam int ARROW_FIRST = 5;
    localparam int ARROW_ROWS  = 4;
    localparam int MAX_RESULTS = 3;

    localparam logic [KEY_W-1:0] KEY_NONE = 25'h1FFFFFF;
    localparam logic [1:0]  FLAG_LONG     = 2'h1;
    localparam logic [1:0]  FLAG_REP      = 2'h2;
    localparam logic [15:0] EV_KEY        = 16'd1;
    localparam logic [15:0] LONG_MS_RST   = 16'd1000;
    localparam logic [15:0] REPEAT_MS_RST = 16'd600;
    localparam logic [1:0]  ROT_90        = 2'd1;
    localparam logic [1:0]  ROT_270       = 2'd3;

    typedef enum logic [1:0] {
        MAP_UPRIGHT,
        MAP_QUARTER,
        MAP_THREE_QUARTER
    } t_map;

    typedef enum logic [1:0] {
        CFG_ROTATION,
        CFG_LONG_MS,
        CFG_REPEAT_MS
    } t_cfg_idx;

    typedef struct packed {
        logic        action;
        logic [15:0] event_type;
        logic [9:0]  raw_code;
        logic [1:0]  raw_value;
    } t_item;

    typedef struct packed {
        logic [1:0]  rotation;
        logic [15:0] long_ms;
        logic [15:0] repeat_ms;
    } t_cfg;

    typedef struct packed {
        logic [KEY_W-1:0] mapped_key;
        logic             is_press;
        logic             is_repeat;
    } t_result;

    typedef struct packed {
        logic [1:0]                   cnt;
        t_result [MAX_RESULTS-1:0]    res;
    } t_grp;

    typedef struct packed {
        logic               found;
        logic [ENTRY_W-1:0] idx;
    } t_hit;

    localparam logic [9:0] ROW_CODE [TABLE_ROWS] = '{
        10'd139, 10'd1,   10'd28,  10'd104, 10'd109, 10'd103, 10'd108, 10'd105, 10'd106,
        10'd115, 10'd114, 10'd191, 10'd192, 10'd193, 10'd194, 10'd116, 10'd190
    };

    localparam logic [KEY_W-1:0] ROW_KEY [TABLE_ROWS] = '{
        25'h1000055, 25'h1000000, 25'h1000004, 25'h1000016, 25'h1000017,
        25'h1000013, 25'h1000015, 25'h1000012, 25'h1000014, 25'h1000072,
        25'h1000070, 25'h1000044, 25'h1000045, 25'h1000046, 25'h1000047,
        25'h1000052, 25'h1000043
    };

    localparam logic [KEY_W-1:0] ROW_LKEY [TABLE_ROWS] = '{
        25'h1000094, 25'h1000010, 25'h1000063, KEY_NONE, KEY_NONE,
        25'h1000013, 25'h1000015, 25'h1000012, 25'h1000014, 25'h1000009,
        25'h1000009, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE,
        25'h1020004, KEY_NONE
    };

    localparam logic [1:0] ROW_FLAGS [TABLE_ROWS] = '{
        FLAG_LONG, FLAG_LONG, FLAG_LONG, 2'h0, 2'h0, FLAG_REP, FLAG_REP, FLAG_REP,
        FLAG_REP, FLAG_LONG, FLAG_LONG, 2'h0, 2'h0, FLAG_REP, 2'h0, FLAG_LONG, 2'h0
    };

    // Arrow keys in up, down, left, right row order for each map.
    localparam logic [KEY_W-1:0] ARROW_KEY [3][ARROW_ROWS] = '{
        '{25'h1000013, 25'h1000015, 25'h1000012, 25'h1000014},
        '{25'h1000014, 25'h1000012, 25'h1000013, 25'h1000015},
        '{25'h1000012, 25'h1000014, 25'h1000015, 25'h1000013}
    };

    function automatic t_map map_of(input logic [1:0] rot);
        t_map m;
        case (rot)
            ROT_90:  m = MAP_QUARTER;
            ROT_270: m = MAP_THREE_QUARTER;
            default: m = MAP_UPRIGHT;
        endcase
        return m;
    endfunction

    // First table row whose code matches; codes in the table are distinct.
    function automatic t_hit find_row(input logic [9:0] code);
        t_hit h;
        h = '0;
        for (int i = SEARCH_ROWS - 1; i >= 0; i--) begin
            if (ROW_CODE[i] == code) begin
                h.found = 1'b1;
                h.idx   = ENTRY_W'(i);
            end
        end
        return h;
    endfunction

    function automatic logic [KEY_W-1:0] key_of(input t_map tbl,
                                                input logic [ENTRY_W-1:0] idx,
                                                input logic lng);
        logic [KEY_W-1:0]   k;
        logic [ENTRY_W-1:0] off;
        k   = KEY_NONE;
        off = idx - ENTRY_W'(ARROW_FIRST);
        if (idx < ENTRY_W'(TABLE_ROWS)) begin
            if (idx >= ENTRY_W'(ARROW_FIRST) && idx < ENTRY_W'(ARROW_FIRST + ARROW_ROWS)) begin
                k = ARROW_KEY[tbl][off[1:0]];
            end else if (lng) begin
                k = ROW_LKEY[idx];
            end else begin
                k = ROW_KEY[idx];
            end
        end
        return k;
    endfunction

    function automatic t_result mk_res(input logic [KEY_W-1:0] key,
                                       input logic press, input logic rep);
        t_result r;
        r.mapped_key = key;
        r.is_press   = press;
        r.is_repeat  = rep;
        return r;
    endfunction

endpackage

`default_nettype wire

### design/klpar_core.sv
// Key state and timers; turns one registered item into a group of results.
`default_nettype none

module klpar_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_go,
    input  wire klpar_pkg::t_item  i_item,
    input  wire klpar_pkg::t_cfg   i_cfg,
    output klpar_pkg::t_grp        o_grp
);
    import klpar_pkg::*;

    `include "key_long_press_auto_repeat_macros.svh"

    logic               r_held_valid, n_held_valid;
    logic [ENTRY_W-1:0] r_held_entry, n_held_entry;
    t_map               r_held_map, n_held_map;
    logic [15:0]        r_long_count, n_long_count;
    logic               r_long_running, n_long_running;
    logic [15:0]        r_repeat_count, n_repeat_count;
    logic               r_repeat_running, n_repeat_running;

    t_hit w_hit;
    t_map w_map;
    logic w_key_hit;
    logic w_press_go;
    logic w_release_go;

    assign w_hit        = find_row(i_item.raw_code);
    assign w_map        = map_of(i_cfg.rotation);
    assign w_key_hit    = !i_item.action && (i_item.event_type == EV_KEY) && w_hit.found;
    assign w_press_go   = i_go && w_key_hit && (i_item.raw_value != 2'd0);
    assign w_release_go = i_go && w_key_hit && (i_item.raw_value == 2'd0);

    always_comb begin
        logic [1:0]       v_n;
        logic             v_started;
        logic [KEY_W-1:0] v_key;

        n_held_valid     = r_held_valid;
        n_held_entry     = r_held_entry;
        n_held_map       = r_held_map;
        n_long_count     = r_long_count;
        n_long_running   = r_long_running;
        n_repeat_count   = r_repeat_count;
        n_repeat_running = r_repeat_running;
        o_grp            = '0;
        v_n              = 2'd0;
        v_started        = 1'b0;
        v_key            = '0;

        if (!i_item.action) begin
            if (w_key_hit) begin
                if (i_item.raw_value != 2'd0) begin
                    n_held_valid   = 1'b1;
                    n_held_entry   = w_hit.idx;
                    n_held_map     = w_map;
                    o_grp.res[0]   = mk_res(key_of(w_map, w_hit.idx, 1'b0), 1'b1, 1'b0);
                    v_n            = 2'd1;
                    n_long_count   = i_cfg.long_ms;
                    n_long_running = 1'b1;
                end else begin
                    // A consumed long-press key gives no release of its own.
                    if ((ROW_FLAGS[w_hit.idx] & FLAG_LONG) == 2'h0 || r_held_valid) begin
                        o_grp.res[0] = mk_res(key_of(w_map, w_hit.idx, 1'b0), 1'b0, 1'b0);
                        v_n          = 2'd1;
                    end
                    n_held_valid     = 1'b0;
                    n_long_running   = 1'b0;
                    n_long_count     = 16'd0;
                    n_repeat_running = 1'b0;
                    n_repeat_count   = 16'd0;
                end
            end
        end else begin
            if (r_long_running) begin
                if (r_long_count <= 16'd1) begin
                    n_long_running = 1'b0;
                    n_long_count   = 16'd0;
                    if (r_held_valid && r_held_entry < ENTRY_W'(TABLE_ROWS)) begin
                        if ((ROW_FLAGS[r_held_entry] & FLAG_REP) != 2'h0) begin
                            n_repeat_count   = i_cfg.repeat_ms;
                            n_repeat_running = 1'b1;
                            v_started        = 1'b1;
                        end else begin
                            v_key = key_of(r_held_map, r_held_entry, 1'b1);
                            if (v_key != KEY_NONE) begin
                                o_grp.res[0] = mk_res(v_key, 1'b0, 1'b0);
                                v_n          = 2'd1;
                                n_held_valid = 1'b0;
                            end
                        end
                    end
                end else begin
                    n_long_count = r_long_count - 16'd1;
                end
            end
            // A repeat timer started on this tick does not count yet.
            if (r_repeat_running && !v_started) begin
                if (r_repeat_count <= 16'd1) begin
                    v_key                = key_of(r_held_map, r_held_entry, 1'b0);
                    o_grp.res[v_n]       = mk_res(v_key, 1'b0, 1'b1);
                    o_grp.res[v_n+2'd1]  = mk_res(v_key, 1'b1, 1'b1);
                    v_n                  = v_n + 2'd2;
                    n_repeat_count       = i_cfg.repeat_ms;
                end else begin
                    n_repeat_count = r_repeat_count - 16'd1;
                end
            end
        end
        o_grp.cnt = v_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid     <= 1'b0;
            r_held_entry     <= '0;
            r_held_map       <= MAP_UPRIGHT;
            r_long_count     <= 16'd0;
            r_long_running   <= 1'b0;
            r_repeat_count   <= 16'd0;
            r_repeat_running <= 1'b0;
        end else if (i_go) begin
            r_held_valid     <= n_held_valid;
            r_held_entry     <= n_held_entry;
            r_held_map       <= n_held_map;
            r_long_count     <= n_long_count;
            r_long_running   <= n_long_running;
            r_repeat_count   <= n_repeat_count;
            r_repeat_running <= n_repeat_running;
        end
    end

    `KLPAR_ASSERT_NEXT(a_press_holds, w_press_go,
        r_held_valid && r_long_running, "press did not hold the key")
    `KLPAR_ASSERT_NEXT(a_release_stops, w_release_go,
        !r_long_running && !r_repeat_running && !r_held_valid, "release left a timer running")
    `KLPAR_ASSERT_SAME(a_key_one_result, !i_item.action,
        o_grp.cnt <= 2'd1, "key event made more than one result")

endmodule

`default_nettype wire

### design/klpar_out.sv
// Result group register that hands out one result per output beat.
`default_nettype none

module klpar_out (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_load,
    input  wire klpar_pkg::t_grp           i_grp,
    output logic                           o_free,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [klpar_pkg::KEY_W-1:0]    o_mapped_key,
    output logic                           o_is_press,
    output logic                           o_is_repeat,
    output logic                           o_last
);
    import klpar_pkg::*;

    `include "key_long_press_auto_repeat_macros.svh"

    t_grp       r_grp;
    logic       r_valid, n_valid;
    logic [1:0] r_pos, n_pos;
    logic       w_last;
    logic       w_take;
    t_result    w_cur;

    assign w_last = (r_pos == r_grp.cnt - 2'd1);
    assign w_take = r_valid && i_ready;
    assign o_free = !r_valid || (w_take && w_last);
    assign w_cur  = r_grp.res[r_pos];

    assign o_valid      = r_valid;
    assign o_mapped_key = w_cur.mapped_key;
    assign o_is_press   = w_cur.is_press;
    assign o_is_repeat  = w_cur.is_repeat;
    assign o_last       = w_last;

    always_comb begin
        n_valid = r_valid;
        n_pos   = r_pos;
        if (w_take) begin
            if (w_last) begin
                n_valid = 1'b0;
            end else begin
                n_pos = r_pos + 2'd1;
            end
        end
        if (i_load) begin
            n_valid = (i_grp.cnt != 2'd0);
            n_pos   = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_grp;
        end
    end

    `KLPAR_ASSERT_SAME(a_group_nonempty, r_valid, r_grp.cnt != 2'd0, "empty group shown as valid")
    `KLPAR_ASSERT_SAME(a_pos_in_group, r_valid, r_pos < r_grp.cnt, "result position past group end")
    `KLPAR_ASSERT_NEXT(a_drain_empties, w_take && w_last && !i_load,
        !r_valid, "group not released after last beat")

endmodule

`default_nettype wire

### design/key_long_press_auto_repeat.sv
// Top level of the key long-press and auto-repeat block.
`default_nettype none

// The block takes one input beat per cycle while its input register can take
// one: a raw key event or a millisecond tick. A beat is held in the input
// register, then the key table lookup, the long-press and repeat timers and the
// result group are worked out combinationally and the group (zero to three
// results) is loaded into the output register. Results leave one per output
// beat, and the output port sets the sustained rate. A new input beat is taken
// while the last result of the previous group is being handed over. There is
// no clearing pass after reset. Configuration writes are always accepted;
// index 0 sets rotation, 1 the long-press time and 2 the repeat interval, in
// ticks, and writes to other indexes are dropped. Write configuration only
// while the block is idle.
module key_long_press_auto_repeat (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Input item channel.
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic                      i_action,
    input  wire logic [15:0]               i_event_type,
    input  wire logic [9:0]                i_raw_code,
    input  wire logic [1:0]                i_raw_value,
    // Configuration write channel.
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [1:0]                i_cfg_index,
    input  wire logic [15:0]               i_cfg_data,
    // Result channel.
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [klpar_pkg::KEY_W-1:0]    o_mapped_key,
    output logic                           o_is_press,
    output logic                           o_is_repeat,
    output logic                           o_last
);
    import klpar_pkg::*;

    // Configuration registers.
    t_cfg  r_cfg;

    // Input register.
    logic  r_in_valid, n_in_valid;
    t_item r_item;

    logic  w_free;
    logic  w_go;
    logic  w_in_take;
    t_grp  w_grp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotation  <= 2'd0;
            r_cfg.long_ms   <= LONG_MS_RST;
            r_cfg.repeat_ms <= REPEAT_MS_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ROTATION:  r_cfg.rotation  <= i_cfg_data[1:0];
                CFG_LONG_MS:   r_cfg.long_ms   <= i_cfg_data;
                CFG_REPEAT_MS: r_cfg.repeat_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The held item is processed as soon as the output register can take its
    // whole group, which is also when the input register can refill.
    assign w_go       = r_in_valid && w_free;
    assign o_in_ready = !r_in_valid || w_free;
    assign w_in_take  = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_take) begin
            n_in_valid = 1'b1;
        end else if (w_go) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item.action     <= i_action;
            r_item.event_type <= i_event_type;
            r_item.raw_code   <= i_raw_code;
            r_item.raw_value  <= i_raw_value;
        end
    end

    // Key state, timers and result generation.
    klpar_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_grp   (w_grp)
    );

    // Result group register and serializer.
    klpar_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_go),
        .i_grp        (w_grp),
        .o_free       (w_free),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_mapped_key (o_mapped_key),
        .o_is_press   (o_is_press),
        .o_is_repeat  (o_is_repeat),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

### sim/key_long_press_auto_repeat_tb.sv
// Self-checking testbench for the key long-press and auto-repeat block.
`default_nettype none

module key_long_press_auto_repeat_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import klpar_pkg::*;

    // Action codes and the one event type that the block handles.
    localparam logic ACT_KEY = 1'b0;
    localparam logic ACT_TICK = 1'b1;
    localparam logic [15:0] KEY_TYPE = 16'd1;
    // Register index outside the register map; the block drops such writes.
    localparam logic [1:0] SPARE_INDEX = 2'd3;

    typedef struct {
        logic [24:0] key;
        logic        press;
        logic        rep;
        logic        last;
    } t_key_result;

    // Tracks the held key and both timers, and keeps the key results still owed.
    class key_result_board;
        localparam logic [24:0] NO_KEY = 25'h1FFFFFF;
        localparam logic [1:0] CAN_LONG = 2'h1;
        localparam logic [1:0] AUTO_REP = 2'h2;

        logic [9:0]  codes[17];
        logic [24:0] keys[17];
        logic [24:0] long_keys[17];
        logic [1:0]  flags[17];
        logic [24:0] arrows[3][4];

        logic [1:0]  rotation;
        logic [15:0] long_ms;
        logic [15:0] repeat_ms;

        bit          held_valid;
        int          held_entry;
        t_map        held_map;
        logic [15:0] long_count;
        logic [15:0] repeat_count;
        bit          long_running;
        bit          repeat_running;

        t_key_result pending_keys[$];
        int          errors;
        int          checked;

        function new();
            codes = '{10'd139, 10'd1, 10'd28, 10'd104, 10'd109, 10'd103, 10'd108, 10'd105,
                      10'd106, 10'd115, 10'd114, 10'd191, 10'd192, 10'd193, 10'd194, 10'd116,
                      10'd190};
            keys = '{25'h1000055, 25'h1000000, 25'h1000004, 25'h1000016, 25'h1000017,
                     25'h1000013, 25'h1000015, 25'h1000012, 25'h1000014, 25'h1000072,
                     25'h1000070, 25'h1000044, 25'h1000045, 25'h1000046, 25'h1000047,
                     25'h1000052, 25'h1000043};
            long_keys = '{25'h1000094, 25'h1000010, 25'h1000063, NO_KEY, NO_KEY,
                          25'h1000013, 25'h1000015, 25'h1000012, 25'h1000014, 25'h1000009,
                          25'h1000009, NO_KEY, NO_KEY, NO_KEY, NO_KEY, 25'h1020004, NO_KEY};
            flags = '{CAN_LONG, CAN_LONG, CAN_LONG, 2'h0, 2'h0, AUTO_REP, AUTO_REP, AUTO_REP,
                      AUTO_REP, CAN_LONG, CAN_LONG, 2'h0, 2'h0, AUTO_REP, 2'h0, CAN_LONG, 2'h0};
            // Up, down, left and right for the upright, quarter and three-quarter maps.
            arrows = '{'{25'h1000013, 25'h1000015, 25'h1000012, 25'h1000014},
                       '{25'h1000014, 25'h1000012, 25'h1000013, 25'h1000015},
                       '{25'h1000012, 25'h1000014, 25'h1000015, 25'h1000013}};
            rotation = 2'd0;
            long_ms = 16'd1000;
            repeat_ms = 16'd600;
            held_valid = 1'b0;
            held_entry = 0;
            held_map = MAP_UPRIGHT;
            long_count = '0;
            repeat_count = '0;
            long_running = 1'b0;
            repeat_running = 1'b0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_ROTATION:  rotation = data[1:0];
                CFG_LONG_MS:   long_ms = data;
                CFG_REPEAT_MS: repeat_ms = data;
                default: ;
            endcase
        endfunction

        function t_map map_for(logic [1:0] rot);
            case (rot)
                ROT_90:  return MAP_QUARTER;
                ROT_270: return MAP_THREE_QUARTER;
                default: return MAP_UPRIGHT;
            endcase
        endfunction

        function logic [24:0] map_key(t_map m, int e, bit lng);
            if (e >= 5 && e <= 8) return arrows[int'(m)][e - 5];
            return lng ? long_keys[e] : keys[e];
        endfunction

        function void owe(logic [24:0] key, logic press, logic rep);
            t_key_result r;
            r.key = key;
            r.press = press;
            r.rep = rep;
            r.last = 1'b0;
            pending_keys.push_back(r);
        endfunction

        // Works out the key results of one accepted input beat; returns their number.
        function int predict_key_results(t_item it);
            int   before_n;
            int   e;
            bit   started;
            t_map m;
            logic [24:0] k;
            before_n = pending_keys.size();
            if (it.action == ACT_KEY) begin
                e = -1;
                for (int i = 0; i < 17; i++) begin
                    if (e < 0 && codes[i] == it.raw_code) e = i;
                end
                if (it.event_type != KEY_TYPE || e < 0) return 0;
                m = map_for(rotation);
                if (it.raw_value != 2'd0) begin
                    held_valid = 1'b1;
                    held_entry = e;
                    held_map = m;
                    owe(map_key(m, e, 1'b0), 1'b1, 1'b0);
                    long_count = long_ms;
                    long_running = 1'b1;
                end else begin
                    // A consumed long-press key releases silently.
                    if ((flags[e] & CAN_LONG) == 2'h0 || held_valid)
                        owe(map_key(m, e, 1'b0), 1'b0, 1'b0);
                    held_valid = 1'b0;
                    long_running = 1'b0;
                    long_count = '0;
                    repeat_running = 1'b0;
                    repeat_count = '0;
                end
            end else begin
                started = 1'b0;
                if (long_running) begin
                    if (long_count <= 16'd1) begin
                        long_running = 1'b0;
                        long_count = '0;
                        if (held_valid) begin
                            if ((flags[held_entry] & AUTO_REP) != 2'h0) begin
                                repeat_count = repeat_ms;
                                repeat_running = 1'b1;
                                started = 1'b1;
                            end else begin
                                k = map_key(held_map, held_entry, 1'b1);
                                if (k != NO_KEY) begin
                                    owe(k, 1'b0, 1'b0);
                                    held_valid = 1'b0;
                                end
                            end
                        end
                    end else begin
                        long_count = long_count - 16'd1;
                    end
                end
                // A repeat timer started on this tick waits for the next one.
                if (repeat_running && !started) begin
                    if (repeat_count <= 16'd1) begin
                        k = map_key(held_map, held_entry, 1'b0);
                        owe(k, 1'b0, 1'b1);
                        owe(k, 1'b1, 1'b1);
                        repeat_count = repeat_ms;
                    end else begin
                        repeat_count = repeat_count - 16'd1;
                    end
                end
            end
            if (pending_keys.size() > before_n)
                pending_keys[pending_keys.size() - 1].last = 1'b1;
            return pending_keys.size() - before_n;
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_key_result(logic [24:0] key, logic press, logic rep, logic last);
            t_key_result exp_r;
            checked++;
            if (pending_keys.size() == 0) begin
                report($sformatf("unexpected result key %h press %b repeat %b last %b",
                                 key, press, rep, last));
                return;
            end
            exp_r = pending_keys.pop_front();
            if (key !== exp_r.key)
                report($sformatf("result %0d: key %h, wanted %h", checked, key, exp_r.key));
            if (press !== exp_r.press)
                report($sformatf("result %0d: press %b, wanted %b", checked, press,
                                 exp_r.press));
            if (rep !== exp_r.rep)
                report($sformatf("result %0d: repeat %b, wanted %b", checked, rep, exp_r.rep));
            if (last !== exp_r.last)
                report($sformatf("result %0d: last %b, wanted %b", checked, last, exp_r.last));
        endtask
    endclass

    // A hung run ends at this limit, which lies far above the slowest correct run.
    localparam int CYCLE_LIMIT = 300000;
    // Length of the one long output stall that fills the block.
    localparam int HOLD_CYCLES = 160;
    // Each random phase stops once this many beats of key sequences have gone in.
    localparam int PHASE_BEATS = 58;

    // Register settings of the random phases: every rotation, zero timers and
    // the largest timers among them. The last phase runs without idling.
    localparam logic [1:0]  PH_ROT[6]  = '{2'd1, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3};
    localparam logic [15:0] PH_LONG[6] = '{16'd1, 16'd0, 16'd5, 16'hFFFF, 16'd12, 16'd2};
    localparam logic [15:0] PH_REP[6]  = '{16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd4, 16'd7};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_action;
    logic [15:0] i_event_type;
    logic [9:0]  i_raw_code;
    logic [1:0]  i_raw_value;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [KEY_W-1:0] o_mapped_key;
    logic        o_is_press;
    logic        o_is_repeat;
    logic        o_last;

    key_long_press_auto_repeat dut (.*);

    key_result_board keys_sb;

    int cycle_count = 0;
    int beats_sent = 0;
    int reg_writes = 0;
    // Chance in percent that a gap or a stall burst starts on a given beat or cycle.
    int in_gap_pct = 0;
    int out_stall_pct = 0;
    // Raised by the stimulus to ask the result side for one long stall.
    bit hold_outputs = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // A run that hangs ends here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Every result beat is checked against the oldest key result still owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            keys_sb.check_key_result(o_mapped_key, o_is_press, o_is_repeat, o_last);
    end

    // Result side: ready is held low in bursts of random length, and once for the
    // long stretch set by HOLD_CYCLES, so that the output register and the input
    // register both fill and the block stops taking input beats.
    initial begin
        int stall;
        stall = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_outputs) begin
                hold_outputs = 1'b0;
                stall = HOLD_CYCLES;
            end else if (stall == 0 && out_stall_pct != 0 &&
                         $urandom_range(0, 99) < out_stall_pct) begin
                stall = $urandom_range(1, 9);
            end
            if (stall > 0) begin
                i_out_ready = 1'b0;
                stall--;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    function automatic t_item make_item(logic act, logic [15:0] ev, logic [9:0] code,
                                        logic [1:0] val);
        t_item it;
        it.action = act;
        it.event_type = ev;
        it.raw_code = code;
        it.raw_value = val;
        return it;
    endfunction

    // A tick carries random values in the fields that it ignores.
    function automatic t_item tick_beat();
        return make_item(ACT_TICK, 16'($urandom), 10'($urandom_range(0, 767)),
                         2'($urandom_range(0, 2)));
    endfunction

    // Offers one input beat after an optional gap and holds it until it is taken.
    // Valid is left high after the beat so that back-to-back beats stay high.
    task automatic send_beat(input t_item it);
        int gap;
        gap = 0;
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct)
            gap = $urandom_range(1, 9);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_action = it.action;
        i_event_type = it.event_type;
        i_raw_code = it.raw_code;
        i_raw_value = it.raw_value;
        do @(posedge i_clk); while (!o_in_ready);
        void'(keys_sb.predict_key_results(it));
        beats_sent++;
    endtask

    // Stops offering beats and waits until every owed result has come out.
    task automatic wait_drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (keys_sb.pending_keys.size() != 0) @(posedge i_clk);
    endtask

    // Register writes happen only on an idle block. A beat with no result may
    // still be in the pipe when the last result leaves, so the clock runs on first.
    task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
        wait_drain();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        keys_sb.write_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // One well-formed key sequence with random content: a press, sometimes a
    // second press that takes over, a run of ticks, then a release that now and
    // then names another key.
    task automatic key_sequence(output int n);
        int e;
        int ticks;
        e = $urandom_range(0, 16);
        send_beat(make_item(ACT_KEY, KEY_TYPE, keys_sb.codes[e], 2'($urandom_range(1, 2))));
        n = 1;
        if ($urandom_range(0, 3) == 0) begin
            e = $urandom_range(0, 16);
            send_beat(make_item(ACT_KEY, KEY_TYPE, keys_sb.codes[e],
                                2'($urandom_range(1, 2))));
            n++;
        end
        ticks = $urandom_range(0, 14);
        repeat (ticks) send_beat(tick_beat());
        n += ticks;
        if ($urandom_range(0, 7) == 0) e = $urandom_range(0, 16);
        send_beat(make_item(ACT_KEY, KEY_TYPE, keys_sb.codes[e], 2'd0));
        n++;
    endtask

    // Beats the block should ignore: foreign event types and unknown codes.
    task automatic noise_beat();
        logic [15:0] ev;
        ev = 16'($urandom);
        if (ev == KEY_TYPE) ev = 16'h0000;
        if ($urandom_range(0, 1) == 0)
            send_beat(make_item(ACT_KEY, ev, 10'($urandom_range(0, 767)),
                                2'($urandom_range(0, 2))));
        else
            send_beat(make_item(ACT_KEY, KEY_TYPE, 10'($urandom_range(195, 767)),
                                2'($urandom_range(0, 2))));
    endtask

    initial begin
        int n;
        int cnt;
        int seq_n;
        bit paused;
        keys_sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = ACT_KEY;
        i_event_type = '0;
        i_raw_code = '0;
        i_raw_value = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ROTATION;
        i_cfg_data = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part under a quarter turn with short timers.
        in_gap_pct = 20;
        out_stall_pct = 20;
        write_register(CFG_ROTATION, 16'd1);
        write_register(CFG_LONG_MS, 16'd2);
        write_register(CFG_REPEAT_MS, 16'd3);
        // An up arrow held until its repeat timer starts; the first repeat tick only counts.
        send_beat(make_item(ACT_KEY, KEY_TYPE, 10'd103, 2'd1));
        send_beat(tick_beat());
        send_beat(tick_beat());
        send_beat(tick_beat());
        // A long-press key takes over while the repeat timer runs. Two ticks
        // later both timers expire together and the tick yields three results.
        send_beat(make_item(ACT_KEY, KEY_TYPE, 10'd28, 2'd2));
        send_beat(tick_beat());
        send_beat(tick_beat());
        // Its long press was consumed, so the release is silent.
        send_beat(make_item(ACT_KEY, KEY_TYPE, 10'd28, 2'd0));
        // A key without a long-press code stays held through its long press.
        send_beat(make_item(ACT_KEY, KEY_TYPE, 10'd104, 2'd1));
        send_beat(tick_beat());
        send_beat(tick_beat());
        send_beat(make_item(ACT_KEY, KEY_TYPE, 10'd104, 2'd0));
        // Releases of keys that are not held.
        send_beat(make_item(ACT_KEY, KEY_TYPE, 10'd139, 2'd0));
        send_beat(make_item(ACT_KEY, KEY_TYPE, 10'd191, 2'd0));
        // Foreign event types at the field extremes and unknown codes.
        send_beat(make_item(ACT_KEY, 16'h0000, 10'd103, 2'd1));
        send_beat(make_item(ACT_KEY, 16'hFFFF, 10'd767, 2'd2));
        send_beat(make_item(ACT_KEY, KEY_TYPE, 10'd0, 2'd1));
        send_beat(make_item(ACT_KEY, KEY_TYPE, 10'd767, 2'd0));
        // A tick with nonzero values in every ignored field, while nothing runs.
        send_beat(make_item(ACT_TICK, 16'hFFFF, 10'd767, 2'd2));
        // Right arrow under a quarter turn, then the power key to its long press.
        send_beat(make_item(ACT_KEY, KEY_TYPE, 10'd106, 2'd1));
        send_beat(make_item(ACT_KEY, KEY_TYPE, 10'd106, 2'd0));
        send_beat(make_item(ACT_KEY, KEY_TYPE, 10'd116, 2'd1));
        send_beat(tick_beat());
        send_beat(tick_beat());
        n = beats_sent;

        for (int phase = 0; phase < 6; phase++) begin
            write_register(CFG_ROTATION, {14'd0, PH_ROT[phase]});
            write_register(CFG_LONG_MS, PH_LONG[phase]);
            write_register(CFG_REPEAT_MS, PH_REP[phase]);
            if (phase == 3) write_register(SPARE_INDEX, 16'hFFFF);
            if (phase == 5) begin
                in_gap_pct = 0;
                out_stall_pct = 0;
            end else begin
                in_gap_pct = 20;
                out_stall_pct = 20;
            end

            if (phase == 0) begin
                // With both timers at one, every tick of a held arrow after the
                // first yields two results; the result side stalls long while the
                // beats keep coming.
                in_gap_pct = 0;
                hold_outputs = 1'b1;
                send_beat(make_item(ACT_KEY, KEY_TYPE, 10'd108, 2'd1));
                repeat (12) send_beat(tick_beat());
                send_beat(make_item(ACT_KEY, KEY_TYPE, 10'd108, 2'd0));
                in_gap_pct = 20;
            end

            cnt = 0;
            paused = 1'b0;
            while (cnt < PHASE_BEATS) begin
                if ($urandom_range(0, 99) < 15) begin
                    noise_beat();
                end else begin
                    key_sequence(seq_n);
                    cnt += seq_n;
                end
                if (phase == 2 && !paused && cnt >= PHASE_BEATS / 2) begin
                    // Mid-phase pause until every owed result has come out.
                    wait_drain();
                    paused = 1'b1;
                end
            end
        end

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (keys_sb.pending_keys.size() != 0)
            keys_sb.report($sformatf("%0d key results never came out",
                                     keys_sb.pending_keys.size()));
        $display("Run covered %0d input beats (%0d directed), %0d result beats checked,",
                 beats_sent, n, keys_sb.checked);
        $display("%0d register writes over all rotations and timers from 0 to 65535.",
                 reg_writes);
        if (keys_sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

`default_nettype wire

### key_long_press_auto_repeat.f
+incdir+design
design/klpar_pkg.sv
design/klpar_core.sv
design/klpar_out.sv
design/key_long_press_auto_repeat.sv
sim/key_long_press_auto_repeat_tb.sv
